// ===== src/assert_macros.svh =====
// assertion macros shared by the ring fifo rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RFS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rfs assertion failed");

// condition must never be true out of reset
`define RFS_NEVER(label, cond) \
  `RFS_ASSERT(label, !(cond))

`endif

// ===== src/rfs_pkg.sv =====
// package for the ring fifo with search: sizes, codes, shared types and helpers
// no dependencies
`timescale 1ns / 1ps

package rfs_pkg;

  localparam int CAPACITY   = 15;
  localparam int DATA_WIDTH = 32;
  localparam int NSLOTS     = CAPACITY + 1;
  localparam int PTR_W      = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

  // field widths of the item channels
  localparam int OPCODE_W   = 2;
  localparam int IO_DATA_W  = 32;
  localparam int IO_SLOT_W  = 4;
  localparam int IO_COUNT_W = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FIND  = 2'd3
  } opcode_e;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic                  ok;
    logic [IO_DATA_W-1:0]  data_out;
    logic [IO_SLOT_W-1:0]  found_slot;
    logic [IO_COUNT_W-1:0] count;
    logic                  full_res;
    logic                  empty_res;
  } rfs_res_t;

  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    word_t wdata;
    logic  re;
    ptr_t  raddr;
  } ram_req_t;

  function automatic ptr_t next_slot(ptr_t p);
    return (p == PTR_W'(NSLOTS - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t fill_count(ptr_t wp, ptr_t rp);
    logic [PTR_W:0] s;
    if (wp >= rp) begin
      s = {1'b0, wp} - {1'b0, rp};
    end else begin
      s = {1'b0, wp} + (PTR_W + 1)'(NSLOTS) - {1'b0, rp};
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic rfs_res_t make_res(logic ok, word_t data, ptr_t slot, ptr_t n);
    rfs_res_t r;
    r.ok         = ok;
    r.data_out   = IO_DATA_W'(data);
    r.found_slot = IO_SLOT_W'(slot);
    r.count      = IO_COUNT_W'(n);
    r.full_res   = (n == PTR_W'(CAPACITY));
    r.empty_res  = (n == '0);
    return r;
  endfunction

endpackage

// ===== src/rfs_if.sv =====
// item channel interfaces of the ring fifo: operation in, result out
// depends on rfs_pkg
`timescale 1ns / 1ps

interface rfs_in_if;
  import rfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [IO_DATA_W-1:0] data_in;
  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface rfs_out_if;
  import rfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [IO_DATA_W-1:0]  data_out;
  logic [IO_SLOT_W-1:0]  found_slot;
  logic [IO_COUNT_W-1:0] count;
  logic                  full_res;
  logic                  empty_res;
  modport source (output valid, output ok, output data_out, output found_slot,
                  output count, output full_res, output empty_res, input ready);
  modport sink   (input valid, input ok, input data_out, input found_slot,
                  input count, input full_res, input empty_res, output ready);
endinterface

// ===== src/rfs_ram.sv =====
// slot storage of the ring fifo: one write port, one registered read port
// depends on rfs_pkg
`timescale 1ns / 1ps

module rfs_ram (
  input  logic              clk_i,
  input  rfs_pkg::ram_req_t req_i,
  output rfs_pkg::word_t    rdata_o
);
  import rfs_pkg::*;

  word_t mem_q [NSLOTS];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rfs_seq.sv =====
// sequencer of the ring fifo: pointers, operation decode and the shared word compare
// depends on rfs_pkg, rfs_ram timing (read data registered, out the cycle after the address)
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfs_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [rfs_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [rfs_pkg::IO_DATA_W-1:0]      data_in_i,
  output logic                               idle_o,
  output logic                               res_valid_o,
  output rfs_pkg::rfs_res_t                  res_o,
  output rfs_pkg::ram_req_t                  ram_o,
  input  rfs_pkg::word_t                     rdata_i
);
  import rfs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN
  } state_e;

  state_e state_q, state_d;
  ptr_t   rp_q, rp_d;
  ptr_t   wp_q, wp_d;
  ptr_t   cur_q, cur_d;    // slot whose word arrives from the ram now
  ptr_t   left_q, left_d;  // slots still to compare, current one included
  word_t  key_q, key_d;

  ptr_t    n;
  word_t   word_in;
  opcode_e op;
  logic    hit;

  assign n       = fill_count(wp_q, rp_q);
  assign word_in = DATA_WIDTH'(data_in_i);
  assign op      = opcode_e'(opcode_i);
  assign hit     = (rdata_i == key_q);
  assign idle_o  = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    cur_d       = cur_q;
    left_d      = left_q;
    key_d       = key_q;
    ram_o       = '0;
    res_valid_o = 1'b0;
    res_o       = make_res(1'b0, '0, '0, n);

    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          unique case (op)
            OP_PUSH: begin
              res_valid_o = 1'b1;
              if (n < PTR_W'(CAPACITY)) begin
                ram_o.we    = 1'b1;
                ram_o.waddr = wp_q;
                ram_o.wdata = word_in;
                wp_d        = next_slot(wp_q);
                res_o       = make_res(1'b1, '0, '0, ptr_t'(n + 1'b1));
              end
            end
            OP_POP: begin
              if (n != '0) begin
                ram_o.re    = 1'b1;
                ram_o.raddr = rp_q;
                state_d     = S_POP;
              end else begin
                res_valid_o = 1'b1;
              end
            end
            OP_CLEAR: begin
              rp_d        = '0;
              wp_d        = '0;
              res_valid_o = 1'b1;
              res_o       = make_res(1'b1, '0, '0, '0);
            end
            OP_FIND: begin
              if (n != '0) begin
                ram_o.re    = 1'b1;
                ram_o.raddr = rp_q;
                cur_d       = rp_q;
                left_d      = n;
                key_d       = word_in;
                state_d     = S_SCAN;
              end else begin
                res_valid_o = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        rp_d        = next_slot(rp_q);
        res_valid_o = 1'b1;
        res_o       = make_res(1'b1, rdata_i, '0, ptr_t'(n - 1'b1));
        state_d     = S_IDLE;
      end
      S_SCAN: begin
        if (hit) begin
          res_valid_o = 1'b1;
          res_o       = make_res(1'b1, '0, cur_q, n);
          state_d     = S_IDLE;
        end else if (left_q == ptr_t'(1)) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = next_slot(cur_q);
          cur_d       = next_slot(cur_q);
          left_d      = ptr_t'(left_q - 1'b1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rp_q    <= '0;
      wp_q    <= '0;
      cur_q   <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      cur_q   <= cur_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // fill level stays within capacity
  `RFS_ASSERT(a_fill_bound, n <= PTR_W'(CAPACITY))
  // the ram is written only by a push taken while idle
  `RFS_NEVER(a_write_when_busy, ram_o.we && (state_q != S_IDLE))
  // a scan never runs past the occupied slots
  `RFS_NEVER(a_scan_overrun, (state_q == S_SCAN) && (left_q == '0))
  // pointers move only as the operation allows
  `RFS_ASSERT(a_scan_keeps_ptrs, (state_q == S_SCAN) |=> $stable(wp_q) && $stable(rp_q))

endmodule

// ===== src/ring_fifo_with_search.sv =====
// top level of the ring fifo with search: channel handshakes and result register
// depends on rfs_pkg, rfs_if, rfs_ram, rfs_seq and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Ring fifo of CAPACITY data words kept in CAPACITY+1 slots, one slot always
// left empty. Each item on the input channel carries one operation: push,
// pop, clear or find. Every item gives exactly one result item with ok, the
// popped word, the slot index found, and the count, full and empty flags after
// the operation. Push and clear finish in the cycle they are accepted, so
// they can stream one item per cycle while results are being taken. Pop
// waits in a second state for the word, since the slot store has a single
// registered read port. Find compares one occupied slot per cycle with a
// single shared comparator, oldest first, and stops at the first hit or
// after the last occupied slot; the input is not ready while a pop or find
// is in progress. A result register sits on the output, so the next item is
// taken in the same cycle a waiting result is taken. Slot contents are not
// cleared by reset or by clear; only the read and write pointers are.
module ring_fifo_with_search (
  input  logic             clk_i,
  input  logic             rst_ni,
  rfs_in_if.sink           in_i,
  rfs_out_if.source        out_o
);
  import rfs_pkg::*;

  logic     accept;
  logic     seq_idle;
  logic     res_valid;
  rfs_res_t res;
  ram_req_t ram_req;
  word_t    ram_rdata;

  logic     out_valid_q, out_valid_d;
  rfs_res_t out_res_q;

  // take an item only when the sequencer is free and the result slot frees up
  assign in_i.ready = seq_idle && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  rfs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (in_i.opcode),
    .data_in_i   (in_i.data_in),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_o       (ram_req),
    .rdata_i     (ram_rdata)
  );

  rfs_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // result register: loaded when an operation finishes, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ok         = out_res_q.ok;
  assign out_o.data_out   = out_res_q.data_out;
  assign out_o.found_slot = out_res_q.found_slot;
  assign out_o.count      = out_res_q.count;
  assign out_o.full_res   = out_res_q.full_res;
  assign out_o.empty_res  = out_res_q.empty_res;

  // a finishing operation never overwrites a result still waiting
  `RFS_ASSERT(a_no_overwrite, res_valid |-> (!out_valid_q || out_o.ready))
  // results come only out of accepted work, never while idle with nothing taken
  `RFS_ASSERT(a_idle_result, (res_valid && seq_idle) |-> accept)

endmodule

// ===== tb/ring_fifo_with_search_test.sv =====
// self-checking testbench for ring_fifo_with_search: directed table, then random items
// depends on rfs_pkg, rfs_if and the ring_fifo_with_search rtl
`timescale 1ns / 1ps

module ring_fifo_with_search_test;
  import rfs_pkg::*;

  // one row of stimulus, with an optional hand-typed expected result
  typedef struct {
    opcode_e     op;
    logic [31:0] data;
    bit          typed;
    rfs_res_t    res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rfs_in_if  op_ch ();
  rfs_out_if res_ch ();

  ring_fifo_with_search u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the fifo, advanced on every accepted item
  word_t      shadow_slots [NSLOTS];
  int         shadow_rd;
  int         shadow_wr;
  rfs_res_t   pending_results [$];
  int         mismatches;

  // sideband that travels with the item on the input channel
  bit         row_typed;
  rfs_res_t   row_res;

  // set for a stretch of the random part: neither side idles then
  bit         no_idle;

  function automatic int shadow_count();
    return (shadow_wr + NSLOTS - shadow_rd) % NSLOTS;
  endfunction

  // apply one operation to the shadow fifo and return the result it gives
  function automatic rfs_res_t apply_fifo_op(opcode_e op, word_t word);
    rfs_res_t r;
    int       n;
    int       p;
    n = shadow_count();
    r = '0;
    case (op)
      OP_PUSH: begin
        if (n < CAPACITY) begin
          shadow_slots[shadow_wr] = word;
          shadow_wr = (shadow_wr + 1) % NSLOTS;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (n != 0) begin
          r.data_out = IO_DATA_W'(shadow_slots[shadow_rd]);
          shadow_rd = (shadow_rd + 1) % NSLOTS;
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_rd = 0;
        shadow_wr = 0;
        r.ok = 1'b1;
      end
      default: begin
        // oldest to newest, occupied slots only; first hit wins
        p = shadow_rd;
        for (int k = 0; k < n; k++) begin
          if (!r.ok && shadow_slots[p] == word) begin
            r.ok = 1'b1;
            r.found_slot = IO_SLOT_W'(p);
          end
          p = (p + 1) % NSLOTS;
        end
      end
    endcase
    n = shadow_count();
    r.count     = IO_COUNT_W'(n);
    r.full_res  = (n == CAPACITY);
    r.empty_res = (n == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result side: ready low in about one cycle of five, except in the quiet stretch
  always @(posedge clk_i) begin
    res_ch.ready <= no_idle || ($urandom_range(99) >= 20);
  end

  // monitor: results are checked before the item taken at the same edge is
  // predicted, since the result register can never hand back that same item
  always @(posedge clk_i) begin
    rfs_res_t want;
    rfs_res_t fresh;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item pending", res_ch.data_out, '0);
        end else begin
          want = pending_results.pop_front();
          if (res_ch.ok !== want.ok)
            report_mismatch("ok", 32'(res_ch.ok), 32'(want.ok));
          if (res_ch.data_out !== want.data_out)
            report_mismatch("data_out", res_ch.data_out, want.data_out);
          if (res_ch.found_slot !== want.found_slot)
            report_mismatch("found_slot", 32'(res_ch.found_slot), 32'(want.found_slot));
          if (res_ch.count !== want.count)
            report_mismatch("count", 32'(res_ch.count), 32'(want.count));
          if (res_ch.full_res !== want.full_res)
            report_mismatch("full_res", 32'(res_ch.full_res), 32'(want.full_res));
          if (res_ch.empty_res !== want.empty_res)
            report_mismatch("empty_res", 32'(res_ch.empty_res), 32'(want.empty_res));
        end
      end
      if (op_ch.valid && op_ch.ready) begin
        // the shadow always advances; a typed row overrides what is expected
        fresh = apply_fifo_op(opcode_e'(op_ch.opcode), word_t'(op_ch.data_in));
        pending_results.push_back(row_typed ? row_res : fresh);
      end
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(stim_row_t row);
    while (!no_idle && $urandom_range(99) < 20) begin
      op_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_ch.valid   <= 1'b1;
    op_ch.opcode  <= row.op;
    op_ch.data_in <= row.data;
    row_typed     <= row.typed;
    row_res       <= row.res;
    do @(posedge clk_i); while (op_ch.ready !== 1'b1);
  endtask

  function automatic stim_row_t plain_row(opcode_e op, logic [31:0] data);
    stim_row_t row;
    row.op    = op;
    row.data  = data;
    row.typed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(opcode_e op, logic [31:0] data, logic ok,
                                         logic [31:0] dout, logic [3:0] slot,
                                         logic [3:0] cnt, logic full, logic empty);
    stim_row_t row;
    row.op             = op;
    row.data           = data;
    row.typed          = 1'b1;
    row.res.ok         = ok;
    row.res.data_out   = dout;
    row.res.found_slot = slot;
    row.res.count      = cnt;
    row.res.full_res   = full;
    row.res.empty_res  = empty;
    return row;
  endfunction

  initial begin
    #3_000_000;
    $display("ring_fifo_with_search regression: fail");
    $finish;
  end

  initial begin
    stim_row_t   table_rows [$];
    logic [31:0] word_pool [6];
    logic [31:0] newest;
    int          push_pct;
    int          pick;
    int          waited;
    opcode_e     op;
    logic [31:0] data;

    // known values on every input from time zero
    rst_ni        = 1'b0;
    op_ch.valid   = 1'b0;
    op_ch.opcode  = OP_PUSH;
    op_ch.data_in = '0;
    row_typed     = 1'b0;
    row_res       = '0;
    no_idle       = 1'b0;
    mismatches    = 0;
    shadow_rd     = 0;
    shadow_wr     = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // directed part: empty-store failures, extremes, full, wrap, clear
    table_rows.push_back(typed_row(OP_POP,  32'h0, 0, 32'h0, 4'd0, 4'd0, 0, 1));
    table_rows.push_back(typed_row(OP_FIND, 32'h0, 0, 32'h0, 4'd0, 4'd0, 0, 1));
    table_rows.push_back(typed_row(OP_PUSH, 32'hffff_ffff, 1, 32'h0, 4'd0, 4'd1, 0, 0));
    table_rows.push_back(typed_row(OP_PUSH, 32'h0, 1, 32'h0, 4'd0, 4'd2, 0, 0));
    table_rows.push_back(typed_row(OP_FIND, 32'h0, 1, 32'h0, 4'd1, 4'd2, 0, 0));
    table_rows.push_back(typed_row(OP_FIND, 32'hffff_ffff, 1, 32'h0, 4'd0, 4'd2, 0, 0));
    table_rows.push_back(typed_row(OP_FIND, 32'h5a5a_5a5a, 0, 32'h0, 4'd0, 4'd2, 0, 0));
    table_rows.push_back(typed_row(OP_POP,  32'h0, 1, 32'hffff_ffff, 4'd0, 4'd1, 0, 0));
    // fill to capacity; the write pointer runs off the last slot and wraps
    newest = '0;
    for (int k = 0; k < CAPACITY - 1; k++) begin
      newest = $urandom;
      table_rows.push_back(plain_row(OP_PUSH, newest));
    end
    table_rows.push_back(typed_row(OP_PUSH, 32'ha5a5_a5a5, 0, 32'h0, 4'd0, 4'd15, 1, 0));
    table_rows.push_back(typed_row(OP_FIND, 32'h0, 1, 32'h0, 4'd1, 4'd15, 1, 0));
    table_rows.push_back(plain_row(OP_FIND, newest));
    table_rows.push_back(typed_row(OP_CLEAR, 32'h0, 1, 32'h0, 4'd0, 4'd0, 0, 1));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) send_item(table_rows[i]);

    // random part: a small pool of words makes finds hit and repeats show up
    foreach (word_pool[i]) word_pool[i] = $urandom;
    push_pct = 45;
    for (int i = 0; i < 1100; i++) begin
      // push bias changes every hundred items so the fifo swings full and empty
      if (i % 100 == 0) begin
        pick = $urandom_range(2);
        push_pct = (pick == 0) ? 20 : (pick == 1) ? 45 : 75;
      end
      no_idle <= (i >= 500 && i < 700);
      pick = $urandom_range(99);
      if (pick < 3)                      op = OP_CLEAR;
      else if (pick < 3 + push_pct)      op = OP_PUSH;
      else if ((pick - push_pct) % 2)    op = OP_POP;
      else                               op = OP_FIND;
      pick = $urandom_range(99);
      if (pick < 60)      data = word_pool[$urandom_range(5)];
      else if (pick < 65) data = 32'h0;
      else if (pick < 70) data = 32'hffff_ffff;
      else                data = $urandom;
      send_item(plain_row(op, data));
    end
    op_ch.valid <= 1'b0;
    no_idle     <= 1'b0;

    // drain: every result should arrive well inside this bound
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("items still waiting for a result", 32'(pending_results.size()), '0);

    if (mismatches == 0) begin
      $display("ring_fifo_with_search regression: pass");
    end else begin
      $display("ring_fifo_with_search regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rfs_pkg.sv
src/rfs_if.sv
src/rfs_ram.sv
src/rfs_seq.sv
src/ring_fifo_with_search.sv
tb/ring_fifo_with_search_test.sv
